>>> src/bsg_pkg.sv
// Shared types and constants for the BMP stream grayscale converter.
// No dependencies; imported by every module under src.
package bsg_pkg;

	localparam int HEADER_BYTES_DEF = 54;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam int POS_W  = 32;
	localparam int BYTE_W = 8;

	// Luma weights, percent
	localparam int W_BLUE  = 11;
	localparam int W_GREEN = 59;
	localparam int W_RED   = 30;

	// Weighted sum tops out at 255*100 = 25500
	localparam int SUM_W = 15;

	// floor(x/100) == (x*5243) >> 19 for all x <= 25500
	localparam int RECIP_W     = 13;
	localparam int RECIP       = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// File size field lives in header bytes 2..5, little-endian
	localparam int SIZE_LO_POS = 2;
	localparam int SIZE_HI_POS = 5;

	// Pixel entries carry three results
	localparam int PIX_RESULTS = 3;
	localparam int SUB_W       = 2;

	typedef enum logic {
		KIND_HDR = 1'b0,
		KIND_PIX = 1'b1
	} bsg_kind_t;

	// One queued job: a header byte to copy, or a pixel sum to scale
	typedef struct packed {
		bsg_kind_t          kind;
		logic [SUM_W-1:0]   data;   // header byte (zero-extended) or weighted sum
		logic [POS_W-1:0]   base;   // offset of the first result
	} bsg_entry_t;

endpackage

>>> src/bmp_stream_grayscale_converter.sv
// Top level of the BMP stream grayscale converter: front end, job queue,
// back end. Depends on bsg_pkg, bsg_front, bsg_queue, bsg_back.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, in_byte, file_start   | in
//   output  | out_valid, out_ready, out_byte,           | out
//           | out_offset, run_last                      |
//
// One input transfer per cycle while the queue has room; a header byte
// yields one result, a red byte inside the file size three, blue/green bytes none.
// The back end issues one result per cycle while out_ready is high, so
// pixel data balances at one result per input byte; the queue absorbs
// the bursts of three. Results pass through the queue and the output register.
// Reset (arst_n) clears position, file size, held bytes, queue and output.
// Output stalls back up through the queue; in_ready drops only when it is full.
module bmp_stream_grayscale_converter import bsg_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              file_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic [POS_W-1:0]  out_offset,
	output logic              run_last
);

	logic       full, empty, push, pop, take;
	bsg_entry_t entry, head;

	// full queue holds off the input; simplest safe rule
	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	bsg_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.file_start(file_start),
		.push      (push),
		.entry     (entry)
	);

	bsg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(entry),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	bsg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_offset(out_offset),
		.run_last  (run_last)
	);

endmodule

>>> src/bsg_front.sv
// Front end: tracks file position, captures file size, holds blue/green
// and builds queue entries. Depends on bsg_pkg.
module bsg_front import bsg_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,        // transfer on the input channel
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              file_start,
	output logic              push,
	output bsg_entry_t        entry
);

	typedef enum logic [2:0] {
		PH_BLUE  = 3'b001,
		PH_GREEN = 3'b010,
		PH_RED   = 3'b100
	} phase_t;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W-1:0] HDR_END = POS_W'(HEADER_BYTES);

	logic [POS_W-1:0]  pos_q, size_q;
	logic [BYTE_W-1:0] blue_q, green_q;
	phase_t            phase_q;

	logic [POS_W-1:0]  pos_w, size_w, size_nx;
	logic [BYTE_W-1:0] blue_w, green_w;
	phase_t            phase_w, phase_nx;
	logic              in_hdr, in_pix, is_red;
	logic [SUM_W-1:0]  sum;

	// file_start restarts everything, with this byte as byte 0
	assign pos_w   = file_start ? '0 : pos_q;
	assign size_w  = file_start ? '0 : size_q;
	assign blue_w  = file_start ? '0 : blue_q;
	assign green_w = file_start ? '0 : green_q;
	assign phase_w = file_start ? PH_BLUE : phase_q;

	assign in_hdr = (pos_w < HDR_END);
	assign in_pix = !in_hdr && (pos_w != POS_MAX);
	assign is_red = in_pix && (phase_w == PH_RED) && (pos_w < size_w);

	assign sum = SUM_W'(blue_w) * SUM_W'(W_BLUE)
	           + SUM_W'(green_w) * SUM_W'(W_GREEN)
	           + SUM_W'(in_byte) * SUM_W'(W_RED);

	always_comb begin
		size_nx = size_w;
		if (in_hdr && pos_w >= POS_W'(SIZE_LO_POS) && pos_w <= POS_W'(SIZE_HI_POS)) begin
			unique case (pos_w[1:0])
				2'd2:    size_nx[7:0]   = in_byte;
				2'd3:    size_nx[15:8]  = in_byte;
				2'd0:    size_nx[23:16] = in_byte;
				2'd1:    size_nx[31:24] = in_byte;
				default: size_nx = size_w;
			endcase
		end
	end

	always_comb begin
		unique case (phase_w)
			PH_BLUE:  phase_nx = PH_GREEN;
			PH_GREEN: phase_nx = PH_RED;
			PH_RED:   phase_nx = PH_BLUE;
			default:  phase_nx = PH_BLUE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			size_q  <= '0;
			blue_q  <= '0;
			green_q <= '0;
			phase_q <= PH_BLUE;
		end else if (take) begin
			pos_q   <= (pos_w == POS_MAX) ? pos_w : pos_w + POS_W'(1);
			size_q  <= size_nx;
			blue_q  <= (in_pix && phase_w == PH_BLUE)  ? in_byte : blue_w;
			green_q <= (in_pix && phase_w == PH_GREEN) ? in_byte : green_w;
			phase_q <= in_pix ? phase_nx : phase_w;
		end
	end

	assign push = take && (in_hdr || is_red);

	always_comb begin
		entry.kind = in_hdr ? KIND_HDR : KIND_PIX;
		entry.data = in_hdr ? SUM_W'(in_byte) : sum;
		entry.base = in_hdr ? pos_w : pos_w - POS_W'(PIX_RESULTS - 1);
	end

endmodule

>>> src/bsg_queue.sv
// Small FIFO between front and back ends.
// Depends on bsg_pkg for the entry type.
module bsg_queue import bsg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bsg_entry_t wr_data,
	input  logic       pop,
	output bsg_entry_t head,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bsg_entry_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/bsg_back.sv
// Back end: passes header bytes through, scales pixel sums to gray, expands each
// pixel to three results and drives the output register. Depends on bsg_pkg.
module bsg_back import bsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bsg_entry_t        head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic [POS_W-1:0]  out_offset,
	output logic              run_last
);

	localparam logic [SUB_W-1:0] LAST_SUB = SUB_W'(PIX_RESULTS - 1);

	logic              out_valid_q, run_last_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [POS_W-1:0]  out_offset_q;
	logic [SUB_W-1:0]  sub_q;

	logic              load, take, is_hdr, last;
	logic [PROD_W-1:0] prod;
	logic [BYTE_W-1:0] gray;

	assign load   = !out_valid_q || out_ready;
	assign take   = load && !empty;
	assign is_hdr = (head.kind == KIND_HDR);
	assign last   = is_hdr || (sub_q == LAST_SUB);
	assign pop    = take && last;

	// divide by 100 through the reciprocal
	assign prod = PROD_W'(head.data) * PROD_W'(RECIP);
	assign gray = prod[RECIP_SHIFT +: BYTE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !empty;
			end
			if (take) begin
				sub_q <= last ? '0 : sub_q + SUB_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q   <= is_hdr ? head.data[BYTE_W-1:0] : gray;
			out_offset_q <= head.base + POS_W'(sub_q);
			run_last_q   <= last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_offset = out_offset_q;
	assign run_last   = run_last_q;

endmodule

>>> dv/tb_bmp_stream_grayscale_converter.sv
// Testbench for bmp_stream_grayscale_converter: streams directed and random 24-bit BMP files
// through the byte channel and checks every output transfer against a scoreboard predictor.
// Depends on bsg_pkg and the converter RTL: the top level with bsg_front, bsg_queue and bsg_back.
`timescale 1ns / 1ps

import bsg_pkg::*;

// Position of a byte within its blue/green/red pixel triple
typedef enum int {
	PH_BLUE  = 0,
	PH_GREEN = 1,
	PH_RED   = 2
} triple_phase_t;

// One output transfer as the block should present it
typedef struct {
	bit [BYTE_W-1:0] pix;
	bit [POS_W-1:0]  offset;
	bit              last;
} out_transfer_t;

class luma_scoreboard;
	bit [POS_W-1:0]  next_pos;
	bit [POS_W-1:0]  file_size;
	bit [BYTE_W-1:0] blue;
	bit [BYTE_W-1:0] green;
	out_transfer_t   due_q[$];
	int unsigned     errors;

	function void restart();
		next_pos  = '0;
		file_size = '0;
		blue      = '0;
		green     = '0;
	endfunction

	function bit [BYTE_W-1:0] luma_of(bit [BYTE_W-1:0] b, bit [BYTE_W-1:0] g,
			bit [BYTE_W-1:0] r);
		int unsigned sum;
		if (b == 8'hFF && g == 8'hFF && r == 8'hFF)
			return 8'hFF;
		sum = int'(b) * W_BLUE + int'(g) * W_GREEN + int'(r) * W_RED;
		return BYTE_W'(sum / 100);
	endfunction

	// Predict the output transfers caused by one accepted input byte
	function void take_file_byte(bit [BYTE_W-1:0] b, bit st);
		bit [POS_W-1:0]  pos;
		bit [BYTE_W-1:0] gray;
		int              k;
		if (st)
			restart();
		pos = next_pos;
		if (pos < HEADER_BYTES_DEF) begin
			if (pos >= SIZE_LO_POS && pos <= SIZE_HI_POS)
				file_size[(pos - SIZE_LO_POS) * 8 +: 8] = b;
			due_q.push_back('{b, pos, 1'b1});
		end else if (pos != '1) begin
			case ((pos - HEADER_BYTES_DEF) % 3)
				PH_BLUE: blue = b;
				PH_GREEN: green = b;
				default: begin
					// triple reaching past the file is dropped
					if (pos < file_size) begin
						gray = luma_of(blue, green, b);
						for (k = 0; k < PIX_RESULTS; k++)
							due_q.push_back('{gray, pos - 2 + k, k == PIX_RESULTS - 1});
					end
				end
			endcase
		end
		if (pos != '1)
			next_pos = pos + 1;
	endfunction

	function void check_output(logic [BYTE_W-1:0] pix, logic [POS_W-1:0] offset, logic last);
		out_transfer_t want;
		if (due_q.size() == 0) begin
			$error("out transfer with nothing due: out_byte %0h, out_offset %0d", pix, offset);
			errors++;
			return;
		end
		want = due_q.pop_front();
		if (pix !== want.pix) begin
			$error("out_byte: expected %0h, actual %0h", want.pix, pix);
			errors++;
		end
		if (offset !== want.offset) begin
			$error("out_offset: expected %0d, actual %0d", want.offset, offset);
			errors++;
		end
		if (last !== want.last) begin
			$error("run_last: expected %0b, actual %0b", want.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return due_q.size();
	endfunction
endclass

module tb_bmp_stream_grayscale_converter;

	localparam int CYCLE_LIMIT  = 400_000;  // slowest legal run stays well under this limit
	localparam int DRAIN_CYCLES = 20;       // leave plenty of slack after the last due transfer
	localparam int TOTAL_ITEMS  = 420;      // directed files included

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] in_byte    = '0;
	logic              file_start = 1'b0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic [POS_W-1:0]  out_offset;
	logic              run_last;

	// Idle rates in percent, changed per test phase
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          sent_count    = 0;
	int unsigned cycle_count   = 0;

	// Bytes of the file being assembled, in file order
	bit [BYTE_W-1:0] file_q[$];

	luma_scoreboard sb = new();

	bmp_stream_grayscale_converter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.file_start (file_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_offset (out_offset),
		.run_last   (run_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random backpressure at the current stall rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Both channels are sampled at the falling edge: all inputs change only at the
	// rising edge, so what is seen here is exactly what the next rising edge accepts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_file_byte(in_byte, file_start);
			if (out_valid && out_ready)
				sb.check_output(out_byte, out_offset, run_last);
		end
	end

	// Hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bmp_stream_grayscale_converter test failed");
			$finish;
		end
	end

	// One input transfer; returns at the rising edge that accepts it.
	// valid stays high straight into the next byte unless an idle gap is drawn.
	task automatic send_byte(input bit [BYTE_W-1:0] b, input bit st);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		in_byte    <= b;
		file_start <= st;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		sent_count++;
	endtask

	// Header with the size field at bytes 2..5, little-endian; the rest random
	task automatic push_header(input bit [POS_W-1:0] size);
		int i;
		for (i = 0; i < HEADER_BYTES_DEF; i++) begin
			if (i >= SIZE_LO_POS && i <= SIZE_HI_POS)
				file_q.push_back(size[(i - SIZE_LO_POS) * 8 +: 8]);
			else
				file_q.push_back($urandom_range(255));
		end
	endtask

	task automatic push_pixel(input bit [BYTE_W-1:0] b, input bit [BYTE_W-1:0] g,
			input bit [BYTE_W-1:0] r);
		file_q.push_back(b);
		file_q.push_back(g);
		file_q.push_back(r);
	endtask

	// Send the first len bytes of the assembled file, then drop the rest
	task automatic send_file(input bit first_start, input int len);
		int i;
		for (i = 0; i < len; i++)
			send_byte(file_q[i], first_start && i == 0);
		file_q.delete();
	endtask

	// Mostly well-formed files; some with bogus sizes, cut short or with trailing junk
	task automatic send_random_file();
		int             npix;
		int             full_len;
		int             len;
		int             i;
		bit [POS_W-1:0] size;
		npix     = $urandom_range(12, 1);
		full_len = HEADER_BYTES_DEF + 3 * npix;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: size = full_len;
			6: size = full_len - $urandom_range(4, 1);      // last triple falls outside
			7: size = $urandom();
			8: size = $urandom_range(HEADER_BYTES_DEF + 2, 0); // too short for any pixel
			default: size = '1;
		endcase
		push_header(size);
		for (i = 0; i < npix; i++) begin
			case ($urandom_range(7))
				0: push_pixel(8'hFF, 8'hFF, 8'hFF);
				1: push_pixel(8'h00, 8'h00, 8'h00);
				2: push_pixel(8'hFF, 8'hFE, 8'hFF);  // just short of white
				default: push_pixel($urandom_range(255), $urandom_range(255),
						$urandom_range(255));
			endcase
		end
		len = full_len;
		case ($urandom_range(9))
			0: len = $urandom_range(full_len - 1, 1);  // next file restarts mid-stream
			1: begin
				repeat ($urandom_range(5, 1))
					file_q.push_back($urandom_range(255));
				len = file_q.size();
			end
			default: ;
		endcase
		send_file(1'b1, len);
	endtask

	initial begin
		int phase;
		int phase_base;
		int phase_goal;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed files, no idling ----
		// Straight out of reset with no file_start marker. Size covers four pixels
		// plus two bytes of a fifth, so the fifth triple is dropped; stray bytes follow.
		push_header(HEADER_BYTES_DEF + 14);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'h00, 8'h00);
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'h00, 8'h00, 8'hFF);
		file_q.push_back(8'h5A);
		file_q.push_back(8'hA5);
		send_file(1'b0, file_q.size());

		// Restart in the middle of the size field
		push_header(HEADER_BYTES_DEF + 3);
		send_file(1'b1, 4);

		// Size too short for any pixel
		push_header(HEADER_BYTES_DEF + 2);
		push_pixel(8'h00, 8'h00, 8'hFF);
		send_file(1'b1, file_q.size());

		// Zero size
		push_header('0);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		send_file(1'b1, file_q.size());

		// Largest size
		push_header('1);
		push_pixel(8'h00, 8'h00, 8'hFF);
		push_pixel(8'hFE, 8'hFF, 8'hFF);
		push_pixel(8'h80, 8'h80, 8'h80);
		send_file(1'b1, file_q.size());

		// ---- random files across the idling phases ----
		// what is left of the byte budget is split evenly; each phase sends at least one file
		phase_goal = (TOTAL_ITEMS - sent_count) / 4;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 88; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 88; end
				default: begin send_idle_pct = 22; stall_pct = 22; end
			endcase
			phase_base = sent_count;
			do
				send_random_file();
			while (sent_count - phase_base < phase_goal);
		end

		in_valid <= 1'b0;

		// Drain: everything due must arrive, then nothing extra may follow
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("bmp_stream_grayscale_converter test passed");
		else
			$display("bmp_stream_grayscale_converter test failed");
		$finish;
	end

endmodule
